// File: sv/sha_pkg.sv
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int BlockWords = 16;
    localparam int Rounds     = 64;

    typedef logic [31:0] word_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t initial_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // start request from the byte front end to the compression engine
    typedef struct packed {
        logic start;
    } comp_req_t;

    typedef struct packed {
        logic busy;
    } comp_stat_t;

endpackage

// File: sv/sha_stream_if.sv
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

// File: sv/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream, one byte per input word. Bytes pack into a
// 16-entry schedule RAM; each full 64-byte block takes a setup step, 64
// rounds and a final add, during which input is held off. The end mark
// pads the rest of the block and the padded block is compressed (both
// twice when the length spills into an extra block), then the eight digest
// words leave one per cycle while the receiver is ready, word 0 first, and
// the hasher returns to its initial state for the next message.
module sha256_byte_stream_hasher (
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    sha_pkg::comp_req_t  req;
    sha_pkg::comp_stat_t stat;
    logic                ld_we, hreset;
    logic [3:0]          ld_addr;
    logic [2:0]          hsel;
    sha_pkg::word_t      ld_data, hword;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .req(req),
        .stat(stat), .ld_we(ld_we), .ld_addr(ld_addr), .ld_data(ld_data),
        .hreset(hreset), .hsel(hsel), .hword(hword)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .req(req), .stat(stat), .ld_we(ld_we),
        .ld_addr(ld_addr), .ld_data(ld_data), .hreset(hreset), .hsel(hsel),
        .hword(hword)
    );
endmodule

// File: sv/sha_ram.sv
module sha_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/sha_core.sv
// Compression engine. The 16-word schedule window lives in a RAM; round t
// reads w[t+1] (or w[t-15] for the expansion) for the next round, and w[t-2],
// w[t-7] come from a small shift line of recent words.
module sha_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::comp_req_t  req,
    output sha_pkg::comp_stat_t stat,
    // schedule RAM port, loaded by the front end while idle
    input  logic                ld_we,
    input  logic [3:0]          ld_addr,
    input  sha_pkg::word_t      ld_data,
    input  logic                hreset,
    input  logic [2:0]          hsel,
    output sha_pkg::word_t      hword
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PRIME = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;
    localparam logic [1:0] S_ADD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [5:0] t_reg, t_next;
    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t hist_reg [8];   // hist[0] = w[t-1] ... hist[7] = w[t-8]
    sha_pkg::word_t w_cur, w15, w16, s0, s1, t1, t2, e, a;

    logic       we;
    logic [3:0] waddr, raddr;
    sha_pkg::word_t wdata, rdata;

    sha_ram #(.Width(32), .Depth(sha_pkg::BlockWords)) u_wram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // rdata holds w[t] for t<16, w[t-16] for t>=16; a separate read of w[t-15]
    // is avoided by keeping w[t-15] in a delay line of the written words.
    // Simplest: rdata at round t = mem[t mod 16] (old value = w[t] or w[t-16]).
    assign raddr = (state_reg == S_IDLE) ? 4'd0 : t_next[3:0];
    assign w16 = rdata;
    // w[t-15] is needed too: kept in a second shift line fed from w_cur
    sha_pkg::word_t ahead_reg [15];  // delay line of written words, w[t-15] at index 0
    assign w15 = ahead_reg[0];

    always_comb
    begin
        if (t_reg < 6'd16)
        begin
            w_cur = w16;
        end
        else
        begin
            s0 = '0;
            w_cur = '0;
        end
        s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1 = sha_pkg::rotr(hist_reg[1], 17) ^ sha_pkg::rotr(hist_reg[1], 19)
             ^ (hist_reg[1] >> 10);
        if (t_reg >= 6'd16)
        begin
            w_cur = w16 + s0 + hist_reg[6] + s1;
        end
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::round_k(t_reg) + w_cur;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        t_next = t_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    state_next = S_PRIME;
                    t_next = '0;
                end
            end
            S_PRIME: state_next = S_ROUND;
            S_ROUND:
            begin
                t_next = t_reg + 6'd1;
                if (t_reg == 6'(sha_pkg::Rounds - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign we = ld_we || (state_reg == S_ROUND);
    assign waddr = ld_we ? ld_addr : t_reg[3:0];
    assign wdata = ld_we ? ld_data : w_cur;
    assign stat.busy = (state_reg != S_IDLE);
    assign hword = h_reg[hsel];

    // The delay line needs w[t-15], the schedule word that follows w[t-16].
    // It is filled with w_cur as rounds proceed; for t<16 the contents are unused.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            t_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::initial_h(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            t_reg <= t_next;
            if (hreset)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= sha_pkg::initial_h(3'(i));
                end
            end
            else if (state_reg == S_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PRIME)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == S_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            hist_reg[0] <= w_cur;
            for (int i = 1; i < 8; i++)
            begin
                hist_reg[i] <= hist_reg[i - 1];
            end
        end
    end

    // w[t-15] for round t equals w[(t+1)-16]: the word written at round t-15.
    // Track written words in a 15-deep line so it is at ahead_reg[0] at round t.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROUND)
        begin
            ahead_reg[14] <= w_cur;
            for (int i = 0; i < 14; i++)
            begin
                ahead_reg[i] <= ahead_reg[i + 1];
            end
        end
    end
endmodule

// File: sv/sha_front.sv
// Byte packing and padding sequencer. Bytes pack into 32-bit words that are
// written to the schedule RAM; padding writes the remaining words one a cycle.
module sha_front (
    input  logic                clk,
    input  logic                rst_n,
    sha_in_if.sink              in_ch,
    sha_out_if.source           out_ch,
    output sha_pkg::comp_req_t  req,
    input  sha_pkg::comp_stat_t stat,
    output logic                ld_we,
    output logic [3:0]          ld_addr,
    output sha_pkg::word_t      ld_data,
    output logic                hreset,
    output logic [2:0]          hsel,
    input  sha_pkg::word_t      hword
);
    localparam logic [2:0] S_TAKE = 3'd0;
    localparam logic [2:0] S_WAIT = 3'd1;
    localparam logic [2:0] S_PAD = 3'd2;
    localparam logic [2:0] S_PWAIT = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] part_reg, part_next;
    logic        fin_reg, fin_next;     // pad byte not yet written
    logic [3:0]  pw_reg, pw_next;       // pad word index
    logic [2:0]  ow_reg, ow_next;
    logic        ov_reg, ov_next;
    logic        acc, pad_has_len;
    sha_pkg::word_t pad_word, byte_word;

    assign in_ch.ready = (state_reg == S_TAKE) && !stat.busy;
    assign acc = in_ch.valid && in_ch.ready;
    assign byte_word = {part_reg, in_ch.data_byte};

    // fill_reg counts bytes already in the block; pw_reg walks from the word
    // holding the pad byte (word 0 in a length-only block) to word 15
    always_comb
    begin
        logic [1:0] bi;
        bi = fill_reg[1:0];
        pad_word = '0;
        if (pw_reg == fill_reg[5:2] && fin_reg)
        begin
            case (bi)
                2'd0: pad_word = 32'h8000_0000;
                2'd1: pad_word = {part_reg[7:0], 24'h80_0000};
                2'd2: pad_word = {part_reg[15:0], 16'h8000};
                default: pad_word = {part_reg, 8'h80};
            endcase
        end
        if (pad_has_len && pw_reg == 4'd14)
        begin
            pad_word = bits_reg[63:32];
        end
        else if (pad_has_len && pw_reg == 4'd15)
        begin
            pad_word = bits_reg[31:0];
        end
    end
    // no room for the length once the pad byte lands past byte 55
    assign pad_has_len = (pw_reg >= 4'd14) && (fill_reg < 6'd56);

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        bits_next = bits_reg;
        part_next = part_reg;
        fin_next = fin_reg;
        pw_next = pw_reg;
        ow_next = ow_reg;
        ov_next = ov_reg;
        ld_we = 1'b0;
        ld_addr = fill_reg[5:2];
        ld_data = byte_word;
        req = '0;
        hreset = 1'b0;
        unique case (state_reg)
            S_TAKE:
            begin
                if (acc)
                begin
                    if (in_ch.byte_valid)
                    begin
                        part_next = {part_reg[15:0], in_ch.data_byte};
                        bits_next = bits_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                        ld_we = (fill_reg[1:0] == 2'd3);
                        if (fill_reg == 6'd63)
                        begin
                            req.start = 1'b1;
                            state_next = in_ch.end_of_message ? S_WAIT : S_TAKE;
                        end
                        else if (in_ch.end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (in_ch.end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                    fin_next = in_ch.end_of_message;
                    pw_next = (in_ch.byte_valid && fill_reg != 6'd63)
                              ? 4'((fill_reg + 6'd1) >> 2) : fill_reg[5:2];
                    if (in_ch.byte_valid && fill_reg == 6'd63)
                    begin
                        pw_next = 4'd0;
                    end
                end
            end
            S_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                // pad byte lands when fill_reg<56 or in the first of two blocks
                ld_we = 1'b1;
                ld_addr = pw_reg;
                ld_data = pad_word;
                if (pw_reg == 4'd15)
                begin
                    req.start = 1'b1;
                    state_next = S_PWAIT;
                end
                else
                begin
                    pw_next = pw_reg + 4'd1;
                end
            end
            S_PWAIT:
            begin
                if (!stat.busy)
                begin
                    if (fill_reg >= 6'd56)
                    begin
                        // second block: only zeros and the length
                        fill_next = '0;
                        pw_next = 4'd0;
                        fin_next = 1'b0;
                        state_next = S_PAD;
                    end
                    else
                    begin
                        ow_next = '0;
                        ov_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    ow_next = ow_reg + 3'd1;
                    if (ow_reg == 3'd7)
                    begin
                        ov_next = 1'b0;
                        hreset = 1'b1;
                        fill_next = '0;
                        bits_next = '0;
                        fin_next = 1'b0;
                        state_next = S_TAKE;
                    end
                end
            end
            default: state_next = S_TAKE;
        endcase
    end

    assign hsel = ow_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.digest_word = hword;
    assign out_ch.word_number = ow_reg;
    assign out_ch.last_word = (ow_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TAKE;
            fill_reg <= '0;
            bits_reg <= '0;
            fin_reg <= 1'b0;
            pw_reg <= '0;
            ow_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            fin_reg <= fin_next;
            pw_reg <= pw_next;
            ow_reg <= ow_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
    end
endmodule

// File: tb/sv/sha256_byte_stream_hasher_tb.sv
module sha256_byte_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef sha_pkg::word_t word_t;

    logic clk;
    logic rst_n;

    sha_in_if  in_ch();
    sha_out_if out_ch();

    sha256_byte_stream_hasher i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } byte_word_t;

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_number;
        logic       last_word;
    } digest_out_t;

    localparam word_t SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam word_t SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predictor state
    word_t       hash_state [8];
    logic [7:0]  block_buf [64];
    int unsigned block_fill;
    logic [63:0] msg_bits;

    digest_out_t expected_digest_q [$];
    byte_word_t  stim_q [$];
    int          error_count;
    int          messages_done;
    int          digest_words_seen;
    bit          stim_done;
    bit          long_stall;

    function automatic word_t ror(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_reset();
        for (int i = 0; i < 8; i++)
            hash_state[i] = SHA_H0[i];
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    function automatic void compress_buf();
        word_t w [64];
        word_t v [8];
        word_t s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    function automatic void predict_digest(byte_word_t b);
        digest_out_t d;
        if (b.byte_valid)
        begin
            block_buf[block_fill] = b.data_byte;
            block_fill++;
            msg_bits += 64'd8;
            if (block_fill == 64)
            begin
                compress_buf();
                block_fill = 0;
            end
        end
        if (!b.end_of_message)
            return;
        block_buf[block_fill] = 8'h80;
        block_fill++;
        if (block_fill > 56)
        begin
            while (block_fill < 64)
            begin
                block_buf[block_fill] = 8'h00;
                block_fill++;
            end
            compress_buf();
            block_fill = 0;
        end
        while (block_fill < 56)
        begin
            block_buf[block_fill] = 8'h00;
            block_fill++;
        end
        for (int i = 0; i < 8; i++)
            block_buf[63-i] = msg_bits[8*i +: 8];
        compress_buf();
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hash_state[i];
            d.word_number = 3'(i);
            d.last_word   = (i == 7);
            expected_digest_q.push_back(d);
        end
        messages_done++;
        hash_reset();
    endfunction

    function automatic void push_msg(int len, bit end_with_byte, int pat);
        byte_word_t b;
        for (int i = 0; i < len; i++)
        begin
            case (pat)
                0: b.data_byte = 8'h00;
                1: b.data_byte = 8'hff;
                2: b.data_byte = 8'(i);
                default: b.data_byte = 8'($urandom_range(0, 255));
            endcase
            b.byte_valid = 1'b1;
            b.end_of_message = end_with_byte && (i == len - 1);
            stim_q.push_back(b);
            // stray idle words in random messages
            if (pat == 3 && $urandom_range(0, 15) == 0)
                stim_q.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
        end
        if (!end_with_byte || len == 0)
            stim_q.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // sender
    initial
    begin
        byte_word_t b;
        int gap;
        // directed lengths: empty, one and three bytes, pad boundaries 55/56, 63, full block
        int dir_len [7] = '{0, 1, 3, 55, 56, 63, 64};
        bit dir_endb [7] = '{0, 1, 0, 1, 1, 0, 1};
        hash_reset();
        error_count = 0;
        messages_done = 0;
        digest_words_seen = 0;
        stim_done = 0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_valid = 1'b0;
        in_ch.end_of_message = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // "abc" has a known digest
        stim_q.push_back('{8'h61, 1'b1, 1'b0});
        stim_q.push_back('{8'h62, 1'b1, 1'b0});
        stim_q.push_back('{8'h63, 1'b1, 1'b1});
        stim_q.push_back('{8'h00, 1'b0, 1'b0});
        for (int i = 0; i < 7; i++)
            push_msg(dir_len[i], dir_endb[i], i % 3);
        for (int n = 0; n < 12; n++)
            push_msg($urandom_range(0, 8), $urandom_range(0, 1), 3);
        while (stim_q.size() > 0)
        begin
            b = stim_q.pop_front();
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.data_byte <= b.data_byte;
            in_ch.byte_valid <= b.byte_valid;
            in_ch.end_of_message <= b.end_of_message;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            predict_digest(b);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // receiver
    initial
    begin
        int gap;
        long_stall = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_stall && messages_done >= 3)
            begin
                long_stall = 1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // checker
    always @(posedge clk)
    begin
        digest_out_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            digest_words_seen++;
            if (expected_digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", out_ch.digest_word);
                error_count++;
            end
            else
            begin
                e = expected_digest_q.pop_front();
                if (digest_words_seen == 1 && e.digest_word != 32'hba7816bf)
                begin
                    $error("digest_word exp %h got %h", 32'hba7816bf, e.digest_word);
                    error_count++;
                end
                if (out_ch.digest_word !== e.digest_word)
                begin
                    $error("digest_word exp %h got %h", e.digest_word, out_ch.digest_word);
                    error_count++;
                end
                if (out_ch.word_number !== e.word_number)
                begin
                    $error("word_number exp %0d got %0d", e.word_number, out_ch.word_number);
                    error_count++;
                end
                if (out_ch.last_word !== e.last_word)
                begin
                    $error("last_word exp %0d got %0d", e.last_word, out_ch.last_word);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_digest_q.size() == 0);
        repeat (200) @(posedge clk);
        if (expected_digest_q.size() != 0)
            error_count++;
        $display("Hashed %0d messages, %0d digest words checked,", messages_done,
                 digest_words_seen);
        $display("including block-boundary lengths, idle words and a long output stall.");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
